>>> rtl/bb3_pkg.sv
// Shared types, constants and helpers for the 3x3 RGB box blur.
package bb3_pkg;

   // Default store sizes handed to the top level
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 4096;

   // Configuration register widths and reset values
   localparam int IMG_W_BITS = 11;
   localparam int IMG_H_BITS = 13;
   localparam int CSR_DATA_W = 13;
   localparam logic [IMG_W_BITS-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [IMG_H_BITS-1:0] HEIGHT_RESET = 13'd480;

   // Sum of nine 8-bit channels and the reciprocal of nine in 0.16 fixed point
   localparam int SUM_W      = 12;
   localparam int RECIP_W    = 13;
   localparam int PROD_W     = SUM_W + RECIP_W;
   localparam int MEAN_SHIFT = 16;
   localparam logic [RECIP_W-1:0] MEAN_RECIP = 13'd7282;

   // Result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = 3;
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   typedef enum logic [0:0] {
      FUNC_PIXEL = 1'b0,
      FUNC_DRAIN = 1'b1
   } func_type;

   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      pixel_type pix;
      logic      last;
   } rsp_word_type;

   // Control that travels with an item through the pipeline
   typedef struct packed {
      logic valid;
      logic pixel;
      logic emit;
      logic interior;
      logic last;
      logic sel_newer;
   } stage_ctrl_type;

   // Queue handshake between the pipeline tail and the result queue
   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctrl_type;

   // Truncated division by nine of a nine-term channel sum
   function automatic logic [7:0] mean9(input logic [SUM_W-1:0] sum);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(sum) * PROD_W'(MEAN_RECIP);
      return prod[MEAN_SHIFT +: 8];
   endfunction

endpackage

>>> rtl/bb3_line_store.sv
// Two row stores sharing one read address and one write address, with write-to-read forwarding.
module bb3_line_store
   import bb3_pkg::*;
#(
   parameter int DEPTH  = MAX_WIDTH_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  pixel_type         wr_older,
   input  pixel_type         wr_newer,
   output pixel_type         rd_older,
   output pixel_type         rd_newer
);

   pixel_type older_mem [DEPTH];
   pixel_type newer_mem [DEPTH];

   pixel_type rd_older_ff;
   pixel_type rd_newer_ff;
   pixel_type fwd_older_ff;
   pixel_type fwd_newer_ff;
   logic      fwd_ff;
   logic      fwd_in;

   // Flag a read that lands on the entry being written this cycle
   assign fwd_in = rd_en && wr_en && (rd_addr == wr_addr);

   // Write the rows, read both at one address
   always_ff @(posedge clock) begin
      if (wr_en) begin
         older_mem[wr_addr] <= wr_older;
         newer_mem[wr_addr] <= wr_newer;
      end
      if (rd_en) begin
         rd_older_ff  <= older_mem[rd_addr];
         rd_newer_ff  <= newer_mem[rd_addr];
         fwd_older_ff <= wr_older;
         fwd_newer_ff <= wr_newer;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= fwd_in;
      end
   end

   // Prefer the word written alongside the read
   assign rd_older = fwd_ff ? fwd_older_ff : rd_older_ff;
   assign rd_newer = fwd_ff ? fwd_newer_ff : rd_newer_ff;

endmodule

>>> rtl/bb3_rsp_fifo.sv
// Result queue between the filter pipeline and the result channel.
module bb3_rsp_fifo
   import bb3_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  fifo_ctrl_type         ctrl,
   input  rsp_word_type          push_word,
   output rsp_word_type          head,
   output logic [FIFO_CNT_W-1:0] count
);

   rsp_word_type             slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]    wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]    wr_ptr_in;
   logic [FIFO_PTR_W-1:0]    rd_ptr_ff;
   logic [FIFO_PTR_W-1:0]    rd_ptr_in;
   logic [FIFO_CNT_W-1:0]    count_ff;
   logic [FIFO_CNT_W-1:0]    count_in;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (ctrl.push) begin
         wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(1);
      end
      if (ctrl.pop) begin
         rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(1);
      end
      if (ctrl.push && !ctrl.pop) begin
         count_in = count_ff + FIFO_CNT_W'(1);
      end else if (ctrl.pop && !ctrl.push) begin
         count_in = count_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold the queued words
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign head  = slot_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

>>> rtl/box_blur_3x3_rgb.sv
// Top level of the streaming 3x3 RGB box blur.
//
// Pixels enter in raster order on the req_ channel (req_func = pixel) and
// leave on the rsp_ channel in the same order. Interior pixels become the
// truncated per-channel mean of their 3x3 neighborhood; pixels of the first
// and last rows and columns pass unchanged. A result word trails its pixel
// by image width + 1 accepted pixels; once the frame's last pixel is in,
// each drain word (or surplus pixel) releases one more result, and the
// frame's final result carries rsp_last_pixel. A drain with nothing pending
// releases nothing. After the final result the next pixel starts a frame.
// Throughput is one word per cycle while req_ready is high: the row stores
// are read and written once per pixel. A released result passes through
// the s1, s2 and s3 stage registers and the result queue to rsp_valid. An
// 8-word result queue absorbs receiver stalls; req_ready drops when the
// queue plus the words in flight fill it, and while a csr_ write is
// offered. Reset sets 640x480 and an empty frame.
// A csr_ write sets image_width or image_height and restarts the frame.
module box_blur_3x3_rgb
   import bb3_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  func_type              req_func,
   input  logic [7:0]            req_red_in,
   input  logic [7:0]            req_green_in,
   input  logic [7:0]            req_blue_in,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_red_out,
   output logic [7:0]            rsp_green_out,
   output logic [7:0]            rsp_blue_out,
   output logic                  rsp_last_pixel,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);

   // Configuration and frame position
   logic [IMG_W_BITS-1:0] width_reg_ff, width_reg_in;
   logic [IMG_H_BITS-1:0] height_reg_ff, height_reg_in;
   logic [COL_W-1:0]      in_col_ff, in_col_in;
   logic [ROW_W-1:0]      in_row_ff, in_row_in;
   logic                  in_done_ff, in_done_in;
   logic                  started_ff, started_in;
   logic [COL_W-1:0]      out_col_ff, out_col_in;
   logic [ROW_W-1:0]      out_row_ff, out_row_in;
   logic [COL_W-1:0]      w_last;
   logic [ROW_W-1:0]      h_last;

   // Accept stage
   logic                  req_fire;
   logic                  csr_fire;
   logic                  take_pixel;
   logic                  s0_emit;
   logic                  s0_last;
   logic                  s0_interior;
   logic [COL_W-1:0]      rd_addr;
   logic                  rd_en;
   pixel_type             req_pix;

   // Pipeline stages
   stage_ctrl_type        s1_ff, s1_in;
   logic [COL_W-1:0]      s1_col_ff;
   pixel_type             s1_pix_ff;
   stage_ctrl_type        s2_ff;
   pixel_type             s2_pass_ff, s2_pass_in;
   stage_ctrl_type        s3_ff;
   pixel_type             s3_pass_ff;
   logic [SUM_W-1:0]      s3_sum_r_ff, s3_sum_r_in;
   logic [SUM_W-1:0]      s3_sum_g_ff, s3_sum_g_in;
   logic [SUM_W-1:0]      s3_sum_b_ff, s3_sum_b_in;
   pixel_type             win_ff [3][3];
   pixel_type             win_in [3][3];

   // Line store and queue
   logic                  ls_wr_en;
   pixel_type             ls_older;
   pixel_type             ls_newer;
   pixel_type             mean_pix;
   fifo_ctrl_type         fifo_ctrl;
   rsp_word_type          push_word;
   rsp_word_type          head;
   logic [FIFO_CNT_W-1:0] fifo_count;
   logic [FIFO_CNT_W-1:0] occupancy;

   // Clamp the configured size into the supported range, minus one
   always_comb begin
      priority if (width_reg_ff == '0) begin
         w_last = '0;
      end else if (32'(width_reg_ff) > MAX_WIDTH) begin
         w_last = COL_W'(MAX_WIDTH - 1);
      end else begin
         w_last = COL_W'(width_reg_ff - IMG_W_BITS'(1));
      end
      priority if (height_reg_ff == '0) begin
         h_last = '0;
      end else if (32'(height_reg_ff) > MAX_HEIGHT) begin
         h_last = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         h_last = ROW_W'(height_reg_ff - IMG_H_BITS'(1));
      end
   end

   // Admit words while the queue has room for everything in flight
   assign occupancy = FIFO_CNT_W'(s1_ff.valid) + FIFO_CNT_W'(s2_ff.valid)
                    + FIFO_CNT_W'(s3_ff.valid) + fifo_count;
   assign req_ready = (occupancy < FIFO_CNT_W'(FIFO_DEPTH)) && !csr_valid;
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;

   // Classify the incoming word against the frame position
   always_comb begin
      req_pix     = '{red: req_red_in, green: req_green_in, blue: req_blue_in};
      take_pixel  = (req_func == FUNC_PIXEL) && !in_done_ff;
      s0_emit     = take_pixel ? started_ff : in_done_ff;
      s0_last     = (out_col_ff == w_last) && (out_row_ff == h_last);
      s0_interior = take_pixel && (out_row_ff != '0) && (out_row_ff < h_last)
                    && (out_col_ff != '0) && (out_col_ff < w_last);
      rd_addr     = take_pixel ? in_col_ff : out_col_ff;
      rd_en       = req_fire && !csr_fire && (take_pixel || in_done_ff);
   end

   // Update configuration and frame counters
   always_comb begin
      width_reg_in  = width_reg_ff;
      height_reg_in = height_reg_ff;
      in_col_in     = in_col_ff;
      in_row_in     = in_row_ff;
      in_done_in    = in_done_ff;
      started_in    = started_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      if (csr_fire) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_reg_in  = csr_wdata[IMG_W_BITS-1:0];
            REG_IMAGE_HEIGHT: height_reg_in = csr_wdata[IMG_H_BITS-1:0];
            default:          width_reg_in  = width_reg_ff;
         endcase
         in_col_in  = '0;
         in_row_in  = '0;
         in_done_in = 1'b0;
         started_in = 1'b0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (req_fire) begin
         if (take_pixel) begin
            if (in_row_ff == ROW_W'(1) && in_col_ff == '0) begin
               started_in = 1'b1;
            end
            if (in_col_ff == w_last) begin
               in_col_in = '0;
               if (in_row_ff == h_last) begin
                  in_done_in = 1'b1;
               end else begin
                  in_row_in = in_row_ff + ROW_W'(1);
               end
            end else begin
               in_col_in = in_col_ff + COL_W'(1);
            end
         end
         if (s0_emit) begin
            if (s0_last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               in_done_in = 1'b0;
               started_in = 1'b0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (out_col_ff == w_last) begin
               out_col_in = '0;
               out_row_in = out_row_ff + ROW_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_reg_ff  <= WIDTH_RESET;
         height_reg_ff <= HEIGHT_RESET;
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         in_done_ff    <= 1'b0;
         started_ff    <= 1'b0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
      end else begin
         width_reg_ff  <= width_reg_in;
         height_reg_ff <= height_reg_in;
         in_col_ff     <= in_col_in;
         in_row_ff     <= in_row_in;
         in_done_ff    <= in_done_in;
         started_ff    <= started_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
      end
   end

   // Stage 1 control word
   always_comb begin
      s1_in.valid     = req_fire && !csr_fire;
      s1_in.pixel     = take_pixel;
      s1_in.emit      = s0_emit;
      s1_in.interior  = s0_interior;
      s1_in.last      = s0_last;
      s1_in.sel_newer = (out_row_ff == h_last);
   end

   // Row stores: read at accept, rotate rows when the data returns
   assign ls_wr_en = s1_ff.valid && s1_ff.pixel;

   bb3_line_store #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (COL_W)
   ) u_line_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .wr_en    (ls_wr_en),
      .wr_addr  (s1_col_ff),
      .wr_older (ls_newer),
      .wr_newer (s1_pix_ff),
      .rd_older (ls_older),
      .rd_newer (ls_newer)
   );

   // Shift a new column into the window; pick the pass-through pixel
   always_comb begin
      win_in = win_ff;
      if (ls_wr_en) begin
         win_in[0]    = win_ff[1];
         win_in[1]    = win_ff[2];
         win_in[2][0] = ls_older;
         win_in[2][1] = ls_newer;
         win_in[2][2] = s1_pix_ff;
      end
      if (s1_ff.pixel) begin
         s2_pass_in = win_ff[2][1];
      end else begin
         s2_pass_in = s1_ff.sel_newer ? ls_newer : ls_older;
      end
   end

   // Stage 2: sum the window per channel
   always_comb begin
      s3_sum_r_in = '0;
      s3_sum_g_in = '0;
      s3_sum_b_in = '0;
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            s3_sum_r_in = s3_sum_r_in + SUM_W'(win_ff[c][r].red);
            s3_sum_g_in = s3_sum_g_in + SUM_W'(win_ff[c][r].green);
            s3_sum_b_in = s3_sum_b_in + SUM_W'(win_ff[c][r].blue);
         end
      end
   end

   // Advance control through the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
         s3_ff <= '0;
      end else begin
         s1_ff <= s1_in;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
      end
   end

   // Advance payload through the stages
   always_ff @(posedge clock) begin
      s1_col_ff   <= rd_addr;
      s1_pix_ff   <= req_pix;
      win_ff      <= win_in;
      s2_pass_ff  <= s2_pass_in;
      s3_pass_ff  <= s2_pass_ff;
      s3_sum_r_ff <= s3_sum_r_in;
      s3_sum_g_ff <= s3_sum_g_in;
      s3_sum_b_ff <= s3_sum_b_in;
   end

   // Stage 3: divide by nine and queue the result
   always_comb begin
      mean_pix.red   = mean9(s3_sum_r_ff);
      mean_pix.green = mean9(s3_sum_g_ff);
      mean_pix.blue  = mean9(s3_sum_b_ff);
      push_word.pix  = s3_ff.interior ? mean_pix : s3_pass_ff;
      push_word.last = s3_ff.last;
      fifo_ctrl.push = s3_ff.valid && s3_ff.emit;
      fifo_ctrl.pop  = rsp_valid && rsp_ready;
   end

   bb3_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (fifo_ctrl),
      .push_word (push_word),
      .head      (head),
      .count     (fifo_count)
   );

   assign rsp_valid      = fifo_count != '0;
   assign rsp_red_out    = head.pix.red;
   assign rsp_green_out  = head.pix.green;
   assign rsp_blue_out   = head.pix.blue;
   assign rsp_last_pixel = head.last;

   // The admission count keeps the queue from overflowing
   a_fifo_room: assert property (@(posedge clock) disable iff (reset)
      fifo_ctrl.push |-> fifo_count < FIFO_CNT_W'(FIFO_DEPTH))
      else $error("result queue push while full");

   // Releasing the frame's final result restarts the frame position
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !csr_fire && s0_emit && s0_last) |=>
      (in_col_ff == '0 && in_row_ff == '0 && !in_done_ff && !started_ff
       && out_col_ff == '0 && out_row_ff == '0))
      else $error("frame position not cleared after final result");

   // Row stores are never written once the frame's pixels are all in
   a_no_write_after_done: assert property (@(posedge clock) disable iff (reset)
      ls_wr_en |-> !$past(in_done_ff))
      else $error("row store written after the frame's last pixel");

endmodule
